// ===== rtl/nodh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nodh_pkg - shared types and constants for the node offline debounce block
// Word formats for the sample and result channels, the register map and the
// reset values used by the configuration port.
// ----------------------------------------------------------------------------
package nodh_pkg;

	// default number of tracked nodes
	localparam int NODES_DEF = 16;

	// field widths fixed by the word formats
	localparam int ID_W    = 4;
	localparam int COUNT_W = 8;
	localparam int CFG_W   = 8;

	// failure count saturates here
	localparam logic [COUNT_W-1:0] FAIL_MAX = '1;

	// configuration port
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic [APB_AW-1:0] ADDR_DEBOUNCE = 3'd0;
	localparam logic [CFG_W-1:0]  DEBOUNCE_RESET = 8'd3;

	// one polled sample
	typedef struct packed {
		logic [3:0]         node_id;
		logic               online;
		logic               press_kind;
		logic               temp_ok;
		logic               press_ok;
		logic [15:0]        raw_reading;
		logic signed [15:0] temp_centi;
		logic [31:0]        press_pa;
		logic [1:0]         alarm;
		logic               bus_fault;
	} sample_t;

	// one reported result
	typedef struct packed {
		logic [3:0]         out_node_id;
		logic               out_online;
		logic               stale;
		logic               out_press_kind;
		logic               out_temp_ok;
		logic               out_press_ok;
		logic [15:0]        out_raw_reading;
		logic signed [15:0] out_temp_centi;
		logic [31:0]        out_press_pa;
		logic [1:0]         out_alarm;
	} result_t;

endpackage

// ===== rtl/nodh_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nodh_cfg - configuration register file
// APB-style slave holding the debounce limit; zero wait states.
// ----------------------------------------------------------------------------
module nodh_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [nodh_pkg::APB_AW-1:0] paddr,
	input  logic [nodh_pkg::APB_DW-1:0] pwdata,
	output logic [nodh_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	output logic [nodh_pkg::CFG_W-1:0]  debounce_rounds
);
	import nodh_pkg::*;

	logic [CFG_W-1:0] debounce_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & (paddr == ADDR_DEBOUNCE);

	// write the limit in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
		end else if (wr_en) begin
			debounce_q <= pwdata[CFG_W-1:0];
		end
	end

	// read back, zero for unmapped addresses
	always_comb begin
		prdata = '0;
		if (paddr == ADDR_DEBOUNCE) begin
			prdata = {{(APB_DW-CFG_W){1'b0}}, debounce_q};
		end
	end

	assign debounce_rounds = debounce_q;

endmodule

// ===== rtl/nodh_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nodh_core - per-node state and result logic
// Holds last good sample, failure count and has-data flag for each node,
// forms the result for the registered sample and updates the node's entry.
// ----------------------------------------------------------------------------
module nodh_core #(
	parameter int NODES = nodh_pkg::NODES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       upd,
	input  nodh_pkg::sample_t          sample,
	input  logic [nodh_pkg::CFG_W-1:0] debounce_rounds,
	output nodh_pkg::result_t          result
);
	import nodh_pkg::*;

	// node_id cannot address more than sixteen entries
	localparam int ENTRIES = (NODES < (1 << ID_W)) ? NODES : (1 << ID_W);
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	typedef struct packed {
		logic               press_kind;
		logic               temp_ok;
		logic               press_ok;
		logic [15:0]        raw_reading;
		logic signed [15:0] temp_centi;
		logic [1:0]         alarm;
		logic [31:0]        press_pa;
	} good_t;

	good_t              good_q  [ENTRIES];
	logic [COUNT_W-1:0] count_q [ENTRIES];
	logic [ENTRIES-1:0] has_q;

	logic               in_range;
	logic [IDX_W-1:0]   idx;
	logic [COUNT_W-1:0] count_nxt;
	logic               keep_on;
	good_t              good_rd;
	good_t              good_in;

	assign in_range = (32'(sample.node_id) < NODES);
	assign idx      = IDX_W'(sample.node_id);
	assign good_rd  = good_q[idx];

	// saturating count after a failed round
	assign count_nxt = (count_q[idx] == FAIL_MAX) ? FAIL_MAX : count_q[idx] + 1'b1;
	assign keep_on   = !sample.bus_fault && (count_nxt < debounce_rounds);

	assign good_in = '{
		press_kind:  sample.press_kind,
		temp_ok:     sample.temp_ok,
		press_ok:    sample.press_ok,
		raw_reading: sample.raw_reading,
		temp_centi:  sample.temp_centi,
		alarm:       sample.alarm,
		press_pa:    sample.press_pa
	};

	// pick pass-through or replay of the stored word
	always_comb begin
		result.out_node_id     = sample.node_id;
		result.out_online      = sample.online;
		result.stale           = 1'b0;
		result.out_press_kind  = sample.press_kind;
		result.out_temp_ok     = sample.temp_ok;
		result.out_press_ok    = sample.press_ok;
		result.out_raw_reading = sample.raw_reading;
		result.out_temp_centi  = sample.temp_centi;
		result.out_press_pa    = sample.press_pa;
		result.out_alarm       = sample.alarm;
		if (in_range && !sample.online && has_q[idx]) begin
			result.out_online      = keep_on;
			result.stale           = 1'b1;
			result.out_press_kind  = good_rd.press_kind;
			result.out_temp_ok     = good_rd.temp_ok;
			result.out_press_ok    = good_rd.press_ok;
			result.out_raw_reading = good_rd.raw_reading;
			result.out_temp_centi  = good_rd.temp_centi;
			result.out_press_pa    = good_rd.press_pa;
			result.out_alarm       = good_rd.alarm;
		end
	end

	// update count and has-data flag of the polled node
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_q <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				count_q[i] <= '0;
			end
		end else if (upd && in_range) begin
			if (sample.online) begin
				has_q[idx]   <= 1'b1;
				count_q[idx] <= '0;
			end else begin
				count_q[idx] <= count_nxt;
			end
		end
	end

	// store a good sample; read only once has-data is set
	always_ff @(posedge clk) begin
		if (upd && in_range && sample.online) begin
			good_q[idx] <= good_in;
		end
	end

endmodule

// ===== rtl/node_offline_debounce_hold.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// node_offline_debounce_hold - offline debounce with hold of last good sample
// Per-node failure debounce; failed rounds replay the last good sample
// marked stale; online only with no bus fault and failures under the limit.
//
//   channel   | signals                                  | dir
//   ----------+------------------------------------------+-----
//   sample    | sample_valid, sample_ready, sample       | in
//   result    | result_valid, result_ready, result       | out
//   config    | psel, penable, pwrite, paddr, pwdata,    | in
//             | prdata, pready                           |
//
// One word per cycle while result_ready is high; results are registered.
// The sample register feeds the node state lookup and update in one pass, so
// back-to-back words to the same node see each other's updates.
// Reset clears every node's count and has-data flag; no clearing pass needed.
// A stalled result holds the pipe; sample_ready falls only when both the
// sample and result registers are full and result_ready is low.
// ----------------------------------------------------------------------------
module node_offline_debounce_hold #(
	parameter int NODES = nodh_pkg::NODES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        sample_valid,
	output logic                        sample_ready,
	input  nodh_pkg::sample_t           sample,
	output logic                        result_valid,
	input  logic                        result_ready,
	output nodh_pkg::result_t           result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [nodh_pkg::APB_AW-1:0] paddr,
	input  logic [nodh_pkg::APB_DW-1:0] pwdata,
	output logic [nodh_pkg::APB_DW-1:0] prdata,
	output logic                        pready
);
	import nodh_pkg::*;

	logic             valid_s1;
	sample_t          word_s1;
	logic             valid_s2;
	result_t          word_s2;
	result_t          result_nxt;
	logic             advance;
	logic [CFG_W-1:0] debounce_rounds;

	// move the registered sample on when the result slot is free
	assign advance      = valid_s1 && (!valid_s2 || result_ready);
	assign sample_ready = !valid_s1 || advance;

	nodh_cfg u_cfg (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.debounce_rounds (debounce_rounds)
	);

	nodh_core #(
		.NODES (NODES)
	) u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.upd             (advance),
		.sample          (word_s1),
		.debounce_rounds (debounce_rounds),
		.result          (result_nxt)
	);

	// pipeline valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (sample_ready) begin
				valid_s1 <= sample_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (result_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// capture sample and result words
	always_ff @(posedge clk) begin
		if (sample_ready && sample_valid) begin
			word_s1 <= sample;
		end
		if (advance) begin
			word_s2 <= result_nxt;
		end
	end

	assign result_valid = valid_s2;
	assign result       = word_s2;

endmodule

// ===== dv/nodh_report_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nodh_report_checker - result predictor and scoreboard for the debounce block
// Watches the sample, result and configuration ports. Keeps its own per-node
// copy of the last good sample, failure run and data flag, predicts one
// report per accepted sample and compares each returned word field by field.
// ----------------------------------------------------------------------------
module nodh_report_checker #(
	parameter int NODES = nodh_pkg::NODES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        sample_valid,
	input  logic                        sample_ready,
	input  nodh_pkg::sample_t           sample,
	input  logic                        result_valid,
	input  logic                        result_ready,
	input  nodh_pkg::result_t           result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic [nodh_pkg::APB_AW-1:0] paddr,
	input  logic [nodh_pkg::APB_DW-1:0] pwdata,
	output int                          pending,
	output int                          mismatches
);
	import nodh_pkg::*;

	localparam int REPORT_LIMIT = 10;

	// per-node history
	sample_t            held_sample [NODES];
	logic [COUNT_W-1:0] miss_run    [NODES];
	bit                 seen_good   [NODES];
	logic [CFG_W-1:0]   offline_after;

	// reports still owed by the block, oldest first
	result_t expected_reports [$];

	// work out the report for one sample and advance the node history
	function automatic result_t predict_report(input sample_t s);
		result_t r;
		int      n;
		n = int'(s.node_id);
		r.out_node_id     = s.node_id;
		r.out_online      = s.online;
		r.stale           = 1'b0;
		r.out_press_kind  = s.press_kind;
		r.out_temp_ok     = s.temp_ok;
		r.out_press_ok    = s.press_ok;
		r.out_raw_reading = s.raw_reading;
		r.out_temp_centi  = s.temp_centi;
		r.out_press_pa    = s.press_pa;
		r.out_alarm       = s.alarm;
		// untracked node: pass through, touch nothing
		if (n >= NODES)
			return r;
		// good round: store and clear the failure run
		if (s.online) begin
			held_sample[n] = s;
			miss_run[n]    = '0;
			seen_good[n]   = 1'b1;
			return r;
		end
		// failed round: count, saturating
		if (miss_run[n] != FAIL_MAX)
			miss_run[n] = miss_run[n] + 1'b1;
		if (!seen_good[n])
			return r;
		// replay the held sample, online only while under the limit and no bus fault
		r.stale           = 1'b1;
		r.out_online      = !s.bus_fault && (miss_run[n] < offline_after);
		r.out_press_kind  = held_sample[n].press_kind;
		r.out_temp_ok     = held_sample[n].temp_ok;
		r.out_press_ok    = held_sample[n].press_ok;
		r.out_raw_reading = held_sample[n].raw_reading;
		r.out_temp_centi  = held_sample[n].temp_centi;
		r.out_press_pa    = held_sample[n].press_pa;
		r.out_alarm       = held_sample[n].alarm;
		return r;
	endfunction

	function automatic string describe(input result_t r);
		return $sformatf({"node %0d on %0b stale %0b kind %0b tv %0b pv %0b",
			" raw %h temp %0d pa %h alarm %0d"},
			r.out_node_id, r.out_online, r.stale, r.out_press_kind, r.out_temp_ok,
			r.out_press_ok, r.out_raw_reading, r.out_temp_centi, r.out_press_pa,
			r.out_alarm);
	endfunction

	// compare returned words, then queue the prediction for each new sample
	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		bit      bad;
		if (!arst_n) begin
			for (int i = 0; i < NODES; i++) begin
				held_sample[i] = '0;
				miss_run[i]    = '0;
				seen_good[i]   = 1'b0;
			end
			offline_after = DEBOUNCE_RESET;
			expected_reports.delete();
			pending    = 0;
			mismatches = 0;
		end else begin
			if (result_valid && result_ready) begin
				got = result;
				if (expected_reports.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("unexpected result word at %0t: %s", $realtime, describe(got));
				end else begin
					want = expected_reports.pop_front();
					bad = (got.out_node_id     !== want.out_node_id)     ||
					      (got.out_online      !== want.out_online)      ||
					      (got.stale           !== want.stale)           ||
					      (got.out_press_kind  !== want.out_press_kind)  ||
					      (got.out_temp_ok     !== want.out_temp_ok)     ||
					      (got.out_press_ok    !== want.out_press_ok)    ||
					      (got.out_raw_reading !== want.out_raw_reading) ||
					      (got.out_temp_centi  !== want.out_temp_centi)  ||
					      (got.out_press_pa    !== want.out_press_pa)    ||
					      (got.out_alarm       !== want.out_alarm);
					if (bad) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT) begin
							$display("result mismatch at %0t", $realtime);
							$display("  expected %s", describe(want));
							$display("  actual   %s", describe(got));
						end
					end
				end
			end
			if (sample_valid && sample_ready)
				expected_reports.insert(expected_reports.size(), predict_report(sample));
			// track the debounce limit as it is written
			if (psel && penable && pwrite && pready && paddr == ADDR_DEBOUNCE)
				offline_after = pwdata[CFG_W-1:0];
			pending = expected_reports.size();
		end
	end

endmodule

// ===== dv/node_offline_debounce_hold_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// node_offline_debounce_hold_tb - regression bench for the debounce block
// Drives directed and random sensor rounds through the sample channel with
// random gaps and result back-pressure, sweeps the debounce limit over its
// extremes and reports a single verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module node_offline_debounce_hold_tb;
	import nodh_pkg::*;

	localparam int STALL_CYCLES = 60;
	localparam int CYCLE_LIMIT  = 150000;
	localparam int RANDOM_ROUNDS = 330;

	logic              clk;
	logic              arst_n;
	logic              sample_valid;
	logic              sample_ready;
	sample_t           sample;
	logic              result_valid;
	logic              result_ready;
	result_t           result;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	int pending;
	int mismatches;
	int tx_idle_pct;
	int rx_idle_pct;
	int stalls_asked;
	int stalls_served;
	int hold_left;
	int cycle_count;

	node_offline_debounce_hold dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	nodh_report_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.pready       (pready),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.pending      (pending),
		.mismatches   (mismatches)
	);

	// 100 MHz clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// result side: random stalls, or a long hold when one is asked for
	initial begin
		result_ready  = 1'b0;
		stalls_served = 0;
		hold_left     = 0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				result_ready = 1'b0;
				hold_left--;
			end else if (stalls_asked != stalls_served) begin
				stalls_served++;
				hold_left    = STALL_CYCLES - 1;
				result_ready = 1'b0;
			end else begin
				result_ready = ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// one round with random content for the given node
	function automatic sample_t make_sample(input logic [3:0] node, input logic up,
			input logic hard);
		sample_t s;
		s.node_id     = node;
		s.online      = up;
		s.press_kind  = 1'($urandom_range(1));
		s.temp_ok     = 1'($urandom_range(1));
		s.press_ok    = 1'($urandom_range(1));
		s.raw_reading = 16'($urandom);
		s.temp_centi  = 16'($urandom);
		s.press_pa    = $urandom;
		s.alarm       = 2'($urandom_range(3));
		s.bus_fault   = hard;
		return s;
	endfunction

	// offer one word, idling first at the sender's rate; entered at a falling edge
	task automatic offer_sample(input sample_t s);
		while ($urandom_range(99) < tx_idle_pct) begin
			sample_valid = 1'b0;
			@(negedge clk);
		end
		sample_valid = 1'b1;
		sample       = s;
		@(posedge clk);
		while (!sample_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// drop valid and wait for every owed report plus the pipe latency
	task automatic settle();
		sample_valid = 1'b0;
		wait (pending == 0);
		repeat (4) @(negedge clk);
	endtask

	// write the debounce limit while the block is idle; upper bits are junk
	task automatic write_debounce(input logic [CFG_W-1:0] limit);
		settle();
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = ADDR_DEBOUNCE;
		pwdata  = {24'($urandom), limit};
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// random rounds, mostly on a few nodes so failure runs build up
	task automatic random_rounds(input int count);
		logic [3:0] node;
		for (int k = 0; k < count; k++) begin
			node = ($urandom_range(99) < 75) ? 4'($urandom_range(3))
			                                 : 4'($urandom_range(15));
			offer_sample(make_sample(node, $urandom_range(99) < 45, $urandom_range(99) < 15));
		end
	endtask

	initial begin
		sample_t s;
		arst_n       = 1'b0;
		sample_valid = 1'b0;
		sample       = '0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		cycle_count  = 0;
		stalls_asked = 0;
		tx_idle_pct  = 16;
		rx_idle_pct  = 77;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed rounds at the reset limit of three
		offer_sample(make_sample(4'd0, 1'b0, 1'b0));       // never good: pass through
		s = '1;
		s.node_id   = 4'd0;
		s.bus_fault = 1'b0;
		offer_sample(s);                                    // good, all ones
		offer_sample(make_sample(4'd0, 1'b0, 1'b0));       // replay, still online
		offer_sample(make_sample(4'd0, 1'b0, 1'b0));
		offer_sample(make_sample(4'd0, 1'b0, 1'b0));       // limit reached: offline
		s = '0;
		s.online = 1'b1;
		offer_sample(s);                                    // good, all zeros
		offer_sample(make_sample(4'd0, 1'b0, 1'b1));       // hard fault forces offline
		offer_sample(make_sample(4'd0, 1'b0, 1'b0));
		s = make_sample(4'd15, 1'b1, 1'b0);
		s.temp_centi = 16'sh8000;
		s.press_pa   = 32'h8000_0000;
		s.alarm      = 2'd1;
		offer_sample(s);
		s = make_sample(4'd15, 1'b1, 1'b1);
		s.temp_centi  = 16'sh7fff;
		s.raw_reading = 16'h8000;
		s.alarm       = 2'd2;
		offer_sample(s);
		offer_sample(make_sample(4'd15, 1'b0, 1'b1));
		offer_sample(make_sample(4'd9, 1'b0, 1'b1));       // never good with hard fault
		s = '1;
		s.node_id = 4'd9;
		s.online  = 1'b0;
		offer_sample(s);

		// zero limit: any failure of a node with data reads offline
		write_debounce(8'd0);
		offer_sample(make_sample(4'd5, 1'b1, 1'b0));
		offer_sample(make_sample(4'd5, 1'b0, 1'b0));
		offer_sample(make_sample(4'd5, 1'b0, 1'b1));

		// top limit: run one node's failure count into saturation
		write_debounce(8'd255);
		offer_sample(make_sample(4'd7, 1'b1, 1'b0));
		for (int k = 0; k < 262; k++)
			offer_sample(make_sample(4'd7, 1'b0, 1'($urandom_range(99) < 5)));
		offer_sample(make_sample(4'd7, 1'b1, 1'b0));
		offer_sample(make_sample(4'd7, 1'b0, 1'b0));

		write_debounce(8'd1);
		random_rounds(RANDOM_ROUNDS);

		// swap the idling sides
		tx_idle_pct = 77;
		rx_idle_pct = 16;
		write_debounce(8'($urandom_range(2, 8)));
		random_rounds(RANDOM_ROUNDS);

		// no idling: hold the result side long enough to back up the input
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_debounce(8'd2);
		stalls_asked++;
		random_rounds(40);
		settle();
		random_rounds(RANDOM_ROUNDS);

		settle();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== node_offline_debounce_hold.f =====
rtl/nodh_pkg.sv
rtl/nodh_cfg.sv
rtl/nodh_core.sv
rtl/node_offline_debounce_hold.sv
dv/nodh_report_checker.sv
dv/node_offline_debounce_hold_tb.sv
